/* src/hat_pkg.sv */
// Shared types, character constants and helper functions for the header
// attribute tokenizer. No dependencies; the unit, its submodules and the testbench import this package.

package hat_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned TOKENS_PER_WORD = 4;
	localparam int unsigned TOK_IW = $clog2(TOKENS_PER_WORD);

	localparam logic [7:0] CH_EQUALS = 8'h3d;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0d;

	typedef enum logic [1:0] {
		KIND_NAME   = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_ATTR   = 2'd2,
		KIND_RECORD = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] tbyte;
	} tok_t;

	// All tokens caused by one input word, in emission order from index 0.
	typedef struct packed {
		tok_t [TOKENS_PER_WORD-1:0] toks;
		logic [TOK_IW:0]            cnt;
	} grp_t;

	typedef struct packed {
		logic valid;
		grp_t grp;
	} grp_chan_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	// Appends one token to a group; the payload byte is zero for markers.
	function automatic grp_t add_tok(input grp_t g, input kind_t k, input logic [7:0] b);
		grp_t r;
		r = g;
		r.toks[g.cnt[TOK_IW-1:0]].kind = k;
		r.toks[g.cnt[TOK_IW-1:0]].tbyte =
			((k == KIND_NAME) || (k == KIND_VALUE)) ? b : 8'h00;
		r.cnt = g.cnt + 1'b1;
		return r;
	endfunction

endpackage

/* src/hat_in_if.sv */
// Input channel of the header attribute tokenizer: one header byte per word.
// Stand-alone interface; no dependencies.

interface hat_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       record_end;

	modport source(output valid, byte_in, record_end, input ready);
	modport sink(input valid, byte_in, record_end, output ready);
endinterface

/* src/hat_out_if.sv */
// Output channel of the header attribute tokenizer: one token per word.
// Stand-alone interface; no dependencies.

interface hat_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] token_kind;
	logic [7:0] token_byte;
	logic       run_last;

	modport source(output valid, token_kind, token_byte, run_last, input ready);
	modport sink(input valid, token_kind, token_byte, run_last, output ready);
endinterface

/* src/header_attribute_tokenizer_unit.sv */
// Top level of the header attribute tokenizer: front end parser, group queue
// and token serializer. Depends on hat_pkg, hat_in_if, hat_out_if and submodules.

// The unit takes the bytes of an HTTP header value, one byte per input word,
// with record_end set on the last byte of the value, and splits the value into
// attributes of the form name, name=value or name="quoted value". Each output
// word is one token: a name byte, a value byte, an attribute end or a record
// end, and run_last marks the final token caused by a given input byte. The
// front end accepts one byte every cycle as long as its four-entry queue of
// token groups has room; a byte that causes no token (skipped whitespace, a
// held '=' or backslash, a consumed comma) never enters the queue. The back
// end presents one token per cycle through a registered output while the
// sink is ready and the queue holds a group, so the sustained rate is one
// byte per cycle while bytes average at most one token each. The first
// token of a byte passes through the group queue and then the output
// register before it is presented. The input never waits on the output
// directly: it stalls only when the queue is full. There are no
// configuration registers.

module header_attribute_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	hat_in_if.sink     in_ch,
	hat_out_if.source  out_ch
);
	import hat_pkg::*;

	grp_chan_t push;
	grp_chan_t head;
	logic      push_ready;
	logic      pop;

	// Parser state and token grouping, one byte per cycle while the queue has room.
	hat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_ready (push_ready),
		.push       (push)
	);

	// Decouples the parser from output back-pressure.
	hat_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	// Serializes each group into single tokens.
	hat_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// An empty group at the head of the queue would never be popped.
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (head.grp.cnt != '0))
		else $error("empty token group reached the queue head");

	// A record end is always the last token that its byte causes.
	a_record_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.token_kind == KIND_RECORD)) |-> out_ch.run_last)
		else $error("record end token not marked as final");

	// The serializer only pops a group when the output register takes a token.
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.valid) |=> out_ch.valid)
		else $error("group popped without presenting a token");
endmodule

/* src/hat_front.sv */
// Front end: accepts header bytes, runs the attribute parser state and builds
// the group of tokens each byte causes. Depends on hat_pkg and hat_in_if.

module hat_front (
	input  logic               clk,
	input  logic               arst_n,
	hat_in_if.sink             in_ch,
	input  logic               push_ready,
	output hat_pkg::grp_chan_t push
);
	import hat_pkg::*;

	typedef enum logic [2:0] {
		MODE_WS     = 3'd0,
		MODE_NAME   = 3'd1,
		MODE_UNQ    = 3'd2,
		MODE_QUOTED = 3'd3,
		MODE_AFTER  = 3'd4
	} mode_t;

	mode_t      mode_q, mode_n;
	logic       held_eq_q, held_eq_n;
	logic       held_bs_q, held_bs_n;
	grp_t       grp;
	logic       name_step;
	logic       accept;
	logic [7:0] b;
	logic       last;

	assign b = in_ch.byte_in;
	assign last = in_ch.record_end;
	assign in_ch.ready = push_ready;
	assign accept = in_ch.valid && push_ready;

	always_comb begin
		grp = '0;
		mode_n = mode_q;
		held_eq_n = held_eq_q;
		held_bs_n = held_bs_q;
		name_step = 1'b0;

		if (held_eq_q) begin
			held_eq_n = 1'b0;
			if (is_ws(b) || (b == CH_EQUALS)) begin
				grp = add_tok(grp, KIND_NAME, CH_EQUALS);
				mode_n = MODE_NAME;
				name_step = 1'b1;
			end else if (b == CH_QUOTE) begin
				mode_n = MODE_QUOTED;
			end else if (b == CH_COMMA) begin
				grp = add_tok(grp, KIND_ATTR, 8'h00);
				mode_n = MODE_WS;
			end else begin
				grp = add_tok(grp, KIND_VALUE, b);
				mode_n = MODE_UNQ;
			end
		end else if (held_bs_q) begin
			held_bs_n = 1'b0;
			grp = add_tok(grp, KIND_VALUE, b);
		end else begin
			case (mode_q)
				MODE_NAME: begin
					name_step = 1'b1;
				end
				MODE_UNQ: begin
					if (is_ws(b) || (b == CH_COMMA)) begin
						grp = add_tok(grp, KIND_ATTR, 8'h00);
						mode_n = MODE_WS;
					end else begin
						grp = add_tok(grp, KIND_VALUE, b);
					end
				end
				MODE_QUOTED: begin
					if (b == CH_QUOTE) begin
						grp = add_tok(grp, KIND_ATTR, 8'h00);
						mode_n = MODE_AFTER;
					end else if ((b == CH_BSLASH) && !last) begin
						held_bs_n = 1'b1;
					end else begin
						grp = add_tok(grp, KIND_VALUE, b);
					end
				end
				MODE_AFTER: begin
					if ((b == CH_COMMA) || is_ws(b)) begin
						mode_n = MODE_WS;
					end else begin
						mode_n = MODE_NAME;
						name_step = 1'b1;
					end
				end
				default: begin
					if (!is_ws(b)) begin
						mode_n = MODE_NAME;
						name_step = 1'b1;
					end
				end
			endcase
		end

		// Byte handling inside a name, shared by several entry paths.
		if (name_step) begin
			if (is_ws(b)) begin
				grp = add_tok(grp, KIND_ATTR, 8'h00);
				mode_n = MODE_WS;
			end else if ((b == CH_EQUALS) && !last) begin
				held_eq_n = 1'b1;
			end else begin
				grp = add_tok(grp, KIND_NAME, b);
			end
		end

		if (last) begin
			if ((mode_n == MODE_NAME) || (mode_n == MODE_UNQ) || (mode_n == MODE_QUOTED)) begin
				grp = add_tok(grp, KIND_ATTR, 8'h00);
			end
			grp = add_tok(grp, KIND_RECORD, 8'h00);
			mode_n = MODE_WS;
			held_eq_n = 1'b0;
			held_bs_n = 1'b0;
		end
	end

	// Bytes that cause no token never enter the queue.
	assign push.valid = in_ch.valid && (grp.cnt != '0);
	assign push.grp = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WS;
			held_eq_q <= 1'b0;
			held_bs_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_n;
			held_eq_q <= held_eq_n;
			held_bs_q <= held_bs_n;
		end
	end
endmodule

/* src/hat_fifo.sv */
// Short queue of token groups between the parser front end and the token
// serializer. Depends on hat_pkg.

module hat_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  hat_pkg::grp_chan_t push,
	output logic               push_ready,
	output hat_pkg::grp_chan_t head,
	input  logic               pop
);
	import hat_pkg::*;

	grp_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign do_push = push.valid && push_ready;
	assign do_pop = pop && head.valid;

	assign head.valid = (count_q != '0);
	assign head.grp = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

/* src/hat_back.sv */
// Back end: walks the token group at the head of the queue and presents one
// token per word through an output register. Depends on hat_pkg, hat_out_if.

module hat_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hat_pkg::grp_chan_t head,
	output logic               pop,
	hat_out_if.source          out_ch
);
	import hat_pkg::*;

	logic [TOK_IW-1:0] idx_q;
	logic              out_valid_q;
	kind_t             kind_q;
	logic [7:0]        tbyte_q;
	logic              run_last_q;
	logic              load;
	logic              grp_done;

	// The output register may take a new token when empty or being drained.
	assign load = head.valid && (!out_valid_q || out_ch.ready);
	assign grp_done = ({1'b0, idx_q} + 1'b1) == head.grp.cnt;
	assign pop = load && grp_done;

	assign out_ch.valid = out_valid_q;
	assign out_ch.token_kind = kind_q;
	assign out_ch.token_byte = tbyte_q;
	assign out_ch.run_last = run_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= head.grp.toks[idx_q].kind;
			tbyte_q <= head.grp.toks[idx_q].tbyte;
			run_last_q <= grp_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= grp_done ? '0 : idx_q + 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

/* tb/sv/header_attribute_tokenizer_unit_tb.sv */
// Self-checking testbench for header_attribute_tokenizer_unit: drives header bytes,
// predicts the token stream in a scoreboard class and checks every output word.
// Depends on hat_pkg, hat_in_if, hat_out_if and the unit itself.

module header_attribute_tokenizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hat_pkg::*;

	// Parser position as the prediction tracks it.
	typedef enum logic [2:0] {
		M_WS     = 3'd0,
		M_NAME   = 3'd1,
		M_UNQ    = 3'd2,
		M_QUOTED = 3'd3,
		M_AFTER  = 3'd4
	} parse_mode_t;

	// One expected output word.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] tbyte;
		logic       run_last;
	} token_exp_t;

	// The scoreboard keeps its own copy of the parser state. Every accepted input
	// byte is turned into the tokens it should cause, and these wait in order
	// until the unit delivers them.
	class token_scoreboard;
		parse_mode_t mode;
		bit          held_eq;
		bit          held_bs;
		token_exp_t  due[$];
		token_exp_t  fresh[$];
		int          errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			mode = M_WS;
			held_eq = 1'b0;
			held_bs = 1'b0;
		endfunction

		// Space, TAB, LF, VT, FF and CR count as whitespace.
		static function bit blank(logic [7:0] b);
			return (b == 8'h20) || (b inside {[8'h09:8'h0d]});
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void put(kind_t k, logic [7:0] b);
			token_exp_t t;
			t.kind = k;
			t.tbyte = ((k == KIND_NAME) || (k == KIND_VALUE)) ? b : 8'h00;
			t.run_last = 1'b0;
			fresh.insert(fresh.size(), t);
		endfunction

		// A byte seen while inside a name. An '=' is held back unless it is the
		// final byte of the record, since only the next byte can tell whether it
		// starts a value.
		function void in_name(logic [7:0] b, logic last);
			if (blank(b)) begin
				put(KIND_ATTR, 8'h00);
				mode = M_WS;
			end else if (b == CH_EQUALS && !last) begin
				held_eq = 1'b1;
			end else begin
				put(KIND_NAME, b);
			end
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			fresh.delete();
			if (held_eq) begin
				held_eq = 1'b0;
				if (blank(b) || b == CH_EQUALS) begin
					put(KIND_NAME, CH_EQUALS);
					mode = M_NAME;
					in_name(b, last);
				end else if (b == CH_QUOTE) begin
					mode = M_QUOTED;
				end else if (b == CH_COMMA) begin
					put(KIND_ATTR, 8'h00);
					mode = M_WS;
				end else begin
					put(KIND_VALUE, b);
					mode = M_UNQ;
				end
			end else if (held_bs) begin
				held_bs = 1'b0;
				put(KIND_VALUE, b);
			end else begin
				case (mode)
					M_NAME: begin
						in_name(b, last);
					end
					M_UNQ: begin
						if (blank(b) || b == CH_COMMA) begin
							put(KIND_ATTR, 8'h00);
							mode = M_WS;
						end else begin
							put(KIND_VALUE, b);
						end
					end
					M_QUOTED: begin
						if (b == CH_QUOTE) begin
							put(KIND_ATTR, 8'h00);
							mode = M_AFTER;
						end else if (b == CH_BSLASH && !last) begin
							held_bs = 1'b1;
						end else begin
							put(KIND_VALUE, b);
						end
					end
					M_AFTER: begin
						if (b == CH_COMMA || blank(b)) begin
							mode = M_WS;
						end else begin
							mode = M_NAME;
							in_name(b, last);
						end
					end
					default: begin
						if (!blank(b)) begin
							mode = M_NAME;
							in_name(b, last);
						end
					end
				endcase
			end
			if (last) begin
				if (mode inside {M_NAME, M_UNQ, M_QUOTED})
					put(KIND_ATTR, 8'h00);
				put(KIND_RECORD, 8'h00);
				restart();
			end
			if (fresh.size() > 0)
				fresh[fresh.size()-1].run_last = 1'b1;
			foreach (fresh[i])
				due.insert(due.size(), fresh[i]);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_token(logic [1:0] k, logic [7:0] tb, logic rl);
			token_exp_t want;
			if (due.size() == 0) begin
				report($sformatf("unexpected token kind %0d byte %02h run_last %0b", k, tb, rl));
				return;
			end
			want = due.pop_front();
			if (want.kind !== kind_t'(k) || want.tbyte !== tb || want.run_last !== rl)
				report($sformatf("got kind %0d byte %02h run_last %0b, wanted %0d %02h %0b",
					k, tb, rl, want.kind, want.tbyte, want.run_last));
		endtask
	endclass

	logic clk;
	logic arst_n;

	hat_in_if  in_ch();
	hat_out_if out_ch();

	header_attribute_tokenizer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	token_scoreboard sb;

	logic [7:0] rec[$];     // bytes of the header value about to be sent
	int         sent;       // input words accepted so far
	bit         steady;     // set near the end: no more idling on either side
	bit         gaps_on;    // source idles within the current record
	int         stall_pct;  // sink stall chance, changed every so often

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the unit hangs. The slowest correct run is far shorter.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Both monitors sample at the rising edge, so they see the values that were
	// present when the handshake happened. The input side is noted first; a byte's
	// tokens cannot leave the unit in the same cycle anyway.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_byte(in_ch.byte_in, in_ch.record_end);
			if (out_ch.valid && out_ch.ready)
				sb.check_token(out_ch.token_kind, out_ch.token_byte, out_ch.run_last);
		end
	end

	// Sink side: ready drops in bursts of random length. The stall chance moves
	// between none, light and heavy, so some stretches run with no back pressure.
	initial begin
		int tick;
		tick = 0;
		stall_pct = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 64 == 0)
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
			if (!steady && $urandom_range(0, 99) < stall_pct) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// Sends one byte and returns once the word has been taken. An idle burst, if
	// any, comes before valid goes up, so valid is never lowered and raised in
	// the same step.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!steady && gaps_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.byte_in <= b;
		in_ch.record_end <= last;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	// Sends the whole of rec as one header value, flagging its final byte.
	task automatic send_record();
		gaps_on = ($urandom_range(0, 9) < 7);
		foreach (rec[i])
			send_byte(rec[i], i == rec.size() - 1);
	endtask

	function automatic logic [7:0] pick_ws();
		return ($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
	endfunction

	// Name and plain value bytes: mostly lowercase letters, sometimes any byte
	// that cannot end or split the field.
	function automatic logic [7:0] pick_plain();
		logic [7:0] b;
		if ($urandom_range(0, 5) == 0) begin
			do b = 8'($urandom_range(0, 255));
			while (token_scoreboard::blank(b) || b == CH_EQUALS || b == CH_COMMA ||
				b == CH_QUOTE);
		end else begin
			b = 8'h61 + 8'($urandom_range(0, 25));
		end
		return b;
	endfunction

	// Noise leans on the bytes that steer the parser.
	function automatic logic [7:0] pick_noise();
		case ($urandom_range(0, 7))
			0: return CH_EQUALS;
			1: return CH_QUOTE;
			2: return CH_BSLASH;
			3: return CH_COMMA;
			4: return pick_ws();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Most records are well formed: one to three attributes, each a bare name,
	// name=value, name="quoted" or name= with an empty value, joined by commas
	// and whitespace. One in five is plain noise.
	task automatic build_random_record();
		int         n_attr;
		logic [7:0] b;
		rec.delete();
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 8)) rec.insert(rec.size(), pick_noise());
			return;
		end
		n_attr = $urandom_range(1, 3);
		for (int a = 0; a < n_attr; a++) begin
			repeat ($urandom_range(0, 1)) rec.insert(rec.size(), pick_ws());
			repeat ($urandom_range(1, 4)) rec.insert(rec.size(), pick_plain());
			case ($urandom_range(0, 3))
				1: begin
					rec.insert(rec.size(), CH_EQUALS);
					repeat ($urandom_range(1, 4)) rec.insert(rec.size(), pick_plain());
				end
				2: begin
					rec.insert(rec.size(), CH_EQUALS);
					rec.insert(rec.size(), CH_QUOTE);
					repeat ($urandom_range(0, 4)) begin
						b = 8'($urandom_range(0, 255));
						if (b == CH_QUOTE || b == CH_BSLASH || $urandom_range(0, 5) == 0)
							rec.insert(rec.size(), CH_BSLASH);
						rec.insert(rec.size(), b);
					end
					// Occasionally the last attribute leaves its quote open.
					if (a < n_attr - 1 || $urandom_range(0, 5) != 0)
						rec.insert(rec.size(), CH_QUOTE);
				end
				3: begin
					rec.insert(rec.size(), CH_EQUALS);
					rec.insert(rec.size(), CH_COMMA);
				end
				default: ;
			endcase
			if (a < n_attr - 1) begin
				case ($urandom_range(0, 3))
					0: rec.insert(rec.size(), CH_COMMA);
					1: rec.insert(rec.size(), pick_ws());
					2: begin
						rec.insert(rec.size(), CH_COMMA);
						rec.insert(rec.size(), CH_SPACE);
					end
					default: rec.insert(rec.size(), CH_COMMA);
				endcase
			end
		end
		if ($urandom_range(0, 4) == 0)
			rec.insert(rec.size(), pick_ws());
	endtask

	initial begin
		sb = new();
		sent = 0;
		steady = 1'b0;
		gaps_on = 1'b0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.byte_in <= 8'h00;
		in_ch.record_end <= 1'b0;
		out_ch.ready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Leading space, a name byte of 0xFF, '=' opening a quoted value that
		// holds a zero byte and an escaped quote, and a backslash as the final
		// byte, which leaves the quote unterminated.
		rec = {CH_SPACE, 8'hff, CH_EQUALS, CH_QUOTE, 8'h00, CH_BSLASH, CH_QUOTE, CH_BSLASH};
		send_record();

		// An empty name "=v", a comma after the value, a name with "==" and then
		// TAB, both of which keep the '=' signs in the name, and '=' as the
		// final byte.
		rec = {CH_EQUALS, 8'h76, CH_COMMA, 8'h62, CH_EQUALS, CH_EQUALS, CH_TAB, CH_EQUALS};
		send_record();

		// x=, gives an empty value; y="" is an empty quoted value, and the z right
		// after the closing quote starts a new name at once.
		rec = {8'h78, CH_EQUALS, CH_COMMA, 8'h79, CH_EQUALS, CH_QUOTE, CH_QUOTE, 8'h7a};
		send_record();

		// A record of whitespace only yields just the record end.
		rec = {CH_CR};
		send_record();

		while (sent < 250) begin
			if (sent >= 200)
				steady = 1'b1;
			build_random_record();
			send_record();
		end
		in_ch.valid <= 1'b0;

		// Drain: everything predicted must arrive, and nothing more may follow.
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
